@@ sv/xor_checked_frame_receiver_core_assert.svh @@
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver_core_assert.svh
// Assertion macros for the framed receiver. ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef XOR_CHECKED_FRAME_RECEIVER_CORE_ASSERT_SVH
`define XOR_CHECKED_FRAME_RECEIVER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked outside reset
`define XCFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, checked outside reset
`define XCFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define XCFR_ASSERT_NOW(lbl, ante, cons, msg)
`define XCFR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ sv/xcfr_pkg.sv @@
// ----------------------------------------------------------------------------
// xcfr_pkg
// Widths, constants and the controller state type of the framed receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package xcfr_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 6;
    localparam int IDX_W       = 5;
    localparam int OUT_BITS    = BYTE_W + LEN_W + IDX_W + BYTE_W;
    localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_CMD,
        ST_LEN,
        ST_DATA,
        ST_SUM,
        ST_RD_ISSUE,
        ST_RD_WAIT
    } xcfr_state_t;

endpackage

`default_nettype wire

@@ sv/xcfr_ram.sv @@
// ----------------------------------------------------------------------------
// xcfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module xcfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/xor_checked_frame_receiver_core.sv @@
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver_core
// Start-marker framed byte receiver with XOR checksum and payload read-out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries received bytes, one per request. The controller hunts
//   for start_marker, takes command and length (a length above MAX_PAYLOAD
//   drops the frame), stores the payload in a RAM and XORs every byte.
//   m_axis carries results. On the checksum byte a bad sum or an empty
//   payload gives one result, registered for the next cycle. A good sum
//   with payload reads the RAM out as a run, each result taking a RAM
//   read (ST_RD_ISSUE), then the output register; reads do not overlap.
//   Header and payload bytes are taken at one per cycle; s_axis_tready is
//   low during the read-out, and on the checksum byte while a result waits
//   unsent in the output register.
//   If the receiver stalls, the output register holds its request and the
//   read-out pauses. Reset puts the block into hunting with an empty output
//   register and start_marker at 0xAA; RAM contents are not cleared.
//   start_marker is written through start_marker_we / start_marker_wdata.
// ----------------------------------------------------------------------------
`default_nettype none

`include "xor_checked_frame_receiver_core_assert.svh"

module xor_checked_frame_receiver_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start_marker_we,
    input  wire logic [xcfr_pkg::BYTE_W-1:0]      start_marker_wdata,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [xcfr_pkg::BYTE_W-1:0]      s_axis_tdata,  // rx_byte
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // frame_command[7:0], payload_length[13:8], payload_index[18:14],
    // payload_byte[26:19], zeros above
    output logic [xcfr_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    output logic                                  m_axis_tlast,  // last_of_run
    output logic [0:0]                            m_axis_tuser   // checksum_good
);

    import xcfr_pkg::*;

    xcfr_state_t       state_reg, state_next;
    logic [BYTE_W-1:0] marker_reg;
    logic [BYTE_W-1:0] cmd_reg, cmd_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;

    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_good_reg, out_good_next;
    logic              out_last_reg, out_last_next;
    logic [BYTE_W-1:0] out_cmd_reg, out_cmd_next;
    logic [LEN_W-1:0]  out_len_reg, out_len_next;

    logic              in_req;
    logic              out_free;
    logic              sum_ok;
    logic              rd_last;
    logic              ram_we;
    logic              ram_re;
    logic [BYTE_W-1:0] ram_rdata;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign in_req   = s_axis_tvalid && s_axis_tready;
    assign sum_ok   = (s_axis_tdata == xor_reg);
    assign rd_last  = ((cnt_reg + LEN_W'(1)) == len_reg);

    always_comb
    begin
        unique case (state_reg) inside
            ST_HUNT, ST_CMD, ST_LEN, ST_DATA: s_axis_tready = 1'b1;
            ST_SUM:                           s_axis_tready = out_free;
            default:                          s_axis_tready = 1'b0;
        endcase
    end

    xcfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PAYLOAD)
    ) u_payload_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[ADDR_W-1:0]),
        .wdata (s_axis_tdata),
        .re    (ram_re),
        .raddr (cnt_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_HUNT:
            begin
                if (in_req && s_axis_tdata == marker_reg)
                begin
                    state_next = ST_CMD;
                end
            end
            ST_CMD:
            begin
                if (in_req)
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (in_req)
                begin
                    if (s_axis_tdata > BYTE_W'(MAX_PAYLOAD))
                    begin
                        state_next = ST_HUNT;
                    end
                    else if (s_axis_tdata == '0)
                    begin
                        state_next = ST_SUM;
                    end
                    else
                    begin
                        state_next = ST_DATA;
                    end
                end
            end
            ST_DATA:
            begin
                if (in_req && rd_last)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (in_req)
                begin
                    state_next = (sum_ok && len_reg != '0) ? ST_RD_ISSUE : ST_HUNT;
                end
            end
            ST_RD_ISSUE:
            begin
                state_next = ST_RD_WAIT;
            end
            ST_RD_WAIT:
            begin
                if (out_free)
                begin
                    state_next = rd_last ? ST_HUNT : ST_RD_ISSUE;
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cmd_next       = cmd_reg;
        len_next       = len_reg;
        xor_next       = xor_reg;
        cnt_next       = cnt_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_idx_next   = out_idx_reg;
        out_byte_next  = out_byte_reg;
        out_good_next  = out_good_reg;
        out_last_next  = out_last_reg;
        out_cmd_next   = out_cmd_reg;
        out_len_next   = out_len_reg;

        unique case (state_reg)
            ST_HUNT:
            begin
                if (in_req && s_axis_tdata == marker_reg)
                begin
                    xor_next = s_axis_tdata;
                end
            end
            ST_CMD:
            begin
                if (in_req)
                begin
                    cmd_next = s_axis_tdata;
                    xor_next = xor_reg ^ s_axis_tdata;
                end
            end
            ST_LEN:
            begin
                if (in_req && s_axis_tdata <= BYTE_W'(MAX_PAYLOAD))
                begin
                    len_next = s_axis_tdata[LEN_W-1:0];
                    xor_next = xor_reg ^ s_axis_tdata;
                    cnt_next = '0;
                end
            end
            ST_DATA:
            begin
                if (in_req)
                begin
                    ram_we   = 1'b1;
                    xor_next = xor_reg ^ s_axis_tdata;
                    cnt_next = cnt_reg + LEN_W'(1);
                end
            end
            ST_SUM:
            begin
                cnt_next = '0;
                // bad sum or empty payload: single closing result
                if (in_req && !(sum_ok && len_reg != '0))
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = '0;
                    out_byte_next  = '0;
                    out_good_next  = sum_ok;
                    out_last_next  = 1'b1;
                    out_cmd_next   = cmd_reg;
                    out_len_next   = len_reg;
                end
            end
            ST_RD_ISSUE:
            begin
                ram_re = 1'b1;
            end
            ST_RD_WAIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = cnt_reg[IDX_W-1:0];
                    out_byte_next  = ram_rdata;
                    out_good_next  = 1'b1;
                    out_last_next  = rd_last;
                    out_cmd_next   = cmd_reg;
                    out_len_next   = len_reg;
                    cnt_next       = cnt_reg + LEN_W'(1);
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_HUNT;
            marker_reg    <= BYTE_W'(170);
            cmd_reg       <= '0;
            len_reg       <= '0;
            xor_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            len_reg       <= len_next;
            xor_reg       <= xor_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (start_marker_we)
            begin
                marker_reg <= start_marker_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_idx_reg  <= out_idx_next;
        out_byte_reg <= out_byte_next;
        out_good_reg <= out_good_next;
        out_last_reg <= out_last_next;
        out_cmd_reg  <= out_cmd_next;
        out_len_reg  <= out_len_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - OUT_BITS)'(0), out_byte_reg, out_idx_reg,
                            out_len_reg, out_cmd_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_good_reg;

    `XCFR_ASSERT_NOW(a_no_input_in_readout,
        (state_reg == ST_RD_ISSUE || state_reg == ST_RD_WAIT), !s_axis_tready,
        "byte accepted during payload read-out")
    `XCFR_ASSERT_NOW(a_error_is_last, (m_axis_tvalid && !m_axis_tuser[0]), m_axis_tlast,
        "checksum error result not marked last")
    `XCFR_ASSERT_NEXT(a_issue_then_wait, (state_reg == ST_RD_ISSUE),
        (state_reg == ST_RD_WAIT), "read issue not followed by data wait")
    `XCFR_ASSERT_NOW(a_write_in_frame, ram_we, (cnt_reg < len_reg),
        "payload write beyond frame length")

endmodule

`default_nettype wire
